### hw/rtl/serial_command_line_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Serial command line decoder assertion macros
// Concurrent assertion helpers shared by the decoder RTL. Defining
// ASSERT_OFF turns every helper into an empty body.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_DECODER_UNIT_MACROS_SVH
`define SERIAL_COMMAND_LINE_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising edge of clk_s while rstn_s is high.
`define SCLD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Checks that a condition never holds while rstn_s is high.
`define SCLD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`else

`define SCLD_ASSERT(lbl, clk_s, rstn_s, prop, msg)

`define SCLD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

### hw/rtl/scld_pkg.sv
// ----------------------------------------------------------------------------
// Serial command line decoder package
// Types, codes and keyword tables of the serial command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  // Width of the configuration write data (widest register).
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_JOG      = 1'b1;

  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd50;
  localparam logic [9:0]  MAX_JOG_RESET      = 10'd20;

  // Number accumulator.
  localparam int unsigned NUM_W       = 11;
  localparam logic [10:0] NUM_SAT     = 11'd2047;
  localparam logic [10:0] ANGLE_LIMIT = 11'd360;

  // Characters of interest.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LOW_S = 8'h73;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  localparam int unsigned NUM_WORDS = 6;
  localparam logic [NUM_WORDS-1:0] ALL_WORDS = 6'h3F;

  // Command kinds. The keyword index equals the kind for the first six.
  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_HELP  = 3'd2,
    KIND_CCW   = 3'd3,
    KIND_CW    = 3'd4,
    KIND_ANGLE = 3'd5,
    KIND_ERROR = 3'd6
  } kind_t;

  // Parse phase of the current line.
  typedef enum logic [3:0] {
    PH_WORD      = 4'd0,
    PH_EXACT     = 4'd1,
    PH_JOG_START = 4'd2,
    PH_JOG_SP    = 4'd3,
    PH_JOG_SIGN  = 4'd4,
    PH_JOG_DIG   = 4'd5,
    PH_ANG_LEAD  = 4'd6,
    PH_ANG_DIG   = 4'd7,
    PH_ANG_TRAIL = 4'd8,
    PH_ERROR     = 4'd9
  } phase_t;

  // Character at position pos of keyword idx, zero past the end.
  function automatic logic [7:0] word_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [39:0] txt;
    logic [39:0] shifted;
    unique case (idx)
      3'd0:    txt = {"read", 8'h00};
      3'd1:    txt = {"stop", 8'h00};
      3'd2:    txt = {"help", 8'h00};
      3'd3:    txt = {"ccw", 16'h0000};
      3'd4:    txt = {"cw", 24'h000000};
      3'd5:    txt = "angle";
      default: txt = '0;
    endcase
    shifted = txt << {pos, 3'b000};
    return shifted[39:32];
  endfunction

  // Length of keyword idx.
  function automatic logic [2:0] word_len(input logic [2:0] idx);
    logic [2:0] len;
    unique case (idx)
      3'd0, 3'd1, 3'd2: len = 3'd4;
      3'd3:             len = 3'd3;
      3'd4:             len = 3'd2;
      3'd5:             len = 3'd5;
      default:          len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/serial_command_line_decoder_unit.sv
// ----------------------------------------------------------------------------
// Serial command line decoder unit
// Decodes received characters and millisecond ticks into command results.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake           Payload
//   -------  ------------------  ---------------------------------------------
//   in       in_valid/in_stall   in_op, in_data_byte
//   out      out_valid/out_stall out_stop_now, out_command_ready,
//                                out_command_kind, out_command_value
//   cfg      cfg_wr_en           cfg_index, cfg_wdata
//
// One item is accepted per cycle. Each accepted item yields exactly one result
// item, which appears in the output register on the cycle after acceptance.
// The line parser, the stop matcher and the idle counter are all updated in the
// same cycle the item is accepted, so the rate is set by that single pass.
// The input stalls only while the output register holds a result that the
// downstream side is stalling; an unstalled result frees it in the same cycle.
// Reset is synchronous and active low; it restores the configuration defaults
// (timeout 50, jog limit 20) and an empty line.
//
module serial_command_line_decoder_unit #(
  parameter int unsigned LINE_MAX = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [7:0]                           in_data_byte,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_stop_now,
  output logic                                 out_command_ready,
  output logic [2:0]                           out_command_kind,
  output logic [9:0]                           out_command_value,

  input  logic                                 cfg_wr_en,
  input  logic [scld_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [scld_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

`include "serial_command_line_decoder_unit_macros.svh"

  // The line holds at most LINE_MAX-1 characters.
  localparam int unsigned LEN_W = $clog2(LINE_MAX);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX - 1);

  // Configuration registers.
  logic [15:0] idle_timeout_r;
  logic [9:0]  max_jog_r;

  // Line state.
  logic [LEN_W-1:0]                   line_len_r, line_len_nxt;
  logic [15:0]                        idle_r, idle_nxt;
  logic [1:0]                         stop_prog_r, stop_prog_nxt;
  scld_pkg::phase_t                   phase_r, phase_nxt;
  logic [scld_pkg::NUM_WORDS-1:0]     mask_r, mask_nxt;
  logic [scld_pkg::NUM_W-1:0]         num_r, num_nxt;
  logic                               num_sat_r, num_sat_nxt;

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  logic                               stop_now_r;
  logic                               cmd_ready_r;
  scld_pkg::kind_t                    cmd_kind_r;
  logic [9:0]                         cmd_value_r;

  // Item decode.
  logic                               in_fire;
  logic [7:0]                         ch;
  logic                               is_digit;
  logic                               is_printable;
  logic                               is_eol;
  logic [8:0]                         pos_ext;
  logic [2:0]                         pos3;
  logic                               pos_zero;
  logic [15:0]                        idle_inc;
  logic                               stop_hit;
  logic                               do_finish;

  // Decimal accumulate: value * 10 + digit, saturating.
  logic [14:0]                        num_ext;
  logic [14:0]                        num_prod;
  logic [scld_pkg::NUM_W-1:0]         add_val;
  logic                               add_sat;

  // Keyword matching.
  logic [scld_pkg::NUM_WORDS-1:0]     match;
  logic [scld_pkg::NUM_WORDS-1:0]     match_m;

  // Line result.
  scld_pkg::kind_t                    fin_kind;
  logic [9:0]                         fin_value;
  scld_pkg::kind_t                    cand_kind;

  // Lowest set candidate, as its command kind.
  function automatic scld_pkg::kind_t low_kind(input logic [scld_pkg::NUM_WORDS-1:0] m);
    scld_pkg::kind_t k;
    k = scld_pkg::KIND_READ;
    for (int i = scld_pkg::NUM_WORDS - 1; i >= 0; i--) begin
      if (m[i]) begin
        k = scld_pkg::kind_t'(3'(i));
      end
    end
    return k;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake: a single output register, refilled in the cycle it drains.
  // --------------------------------------------------------------------------
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign out_valid         = out_valid_r;
  assign out_stop_now      = stop_now_r;
  assign out_command_ready = cmd_ready_r;
  assign out_command_kind  = cmd_kind_r;
  assign out_command_value = cmd_value_r;

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Character classification. Upper-case letters fold to lower case.
  // --------------------------------------------------------------------------
  always_comb begin
    if (in_data_byte >= scld_pkg::CH_UA && in_data_byte <= scld_pkg::CH_UZ) begin
      ch = in_data_byte | 8'h20;
    end else begin
      ch = in_data_byte;
    end
  end

  assign is_digit     = (ch >= scld_pkg::CH_ZERO) && (ch <= scld_pkg::CH_NINE);
  assign is_printable = (in_data_byte >= scld_pkg::CH_PRINT_LO) &&
                        (in_data_byte <= scld_pkg::CH_PRINT_HI);
  assign is_eol       = (in_data_byte == scld_pkg::CH_CR) ||
                        (in_data_byte == scld_pkg::CH_LF);

  assign pos_ext  = 9'(line_len_r);
  assign pos3     = pos_ext[2:0];
  assign pos_zero = (line_len_r == '0);
  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;

  // The multiply by ten is a shift-and-add on a 15-bit value.
  assign num_ext  = 15'(num_r);
  assign num_prod = (num_ext << 3) + (num_ext << 1) + 15'(ch[3:0]);

  always_comb begin
    if (num_sat_r || num_prod > 15'(scld_pkg::NUM_SAT)) begin
      add_val = scld_pkg::NUM_SAT;
      add_sat = 1'b1;
    end else begin
      add_val = num_prod[scld_pkg::NUM_W-1:0];
      add_sat = 1'b0;
    end
  end

  // A keyword stays a candidate while its character at this position matches.
  always_comb begin
    for (int i = 0; i < scld_pkg::NUM_WORDS; i++) begin
      match[i] = (pos_ext < 9'(scld_pkg::word_len(3'(i)))) &&
                 (scld_pkg::word_char(3'(i), pos3) == ch);
    end
  end
  assign match_m = match & mask_r;

  // Stop matcher: progress through "stop", restarting on an 's'.
  always_comb begin
    stop_hit      = 1'b0;
    stop_prog_nxt = stop_prog_r;
    if (in_fire && !in_op) begin
      if (ch == scld_pkg::word_char(3'(scld_pkg::KIND_STOP), {1'b0, stop_prog_r})) begin
        if (stop_prog_r == 2'd3) begin
          stop_hit      = 1'b1;
          stop_prog_nxt = 2'd0;
        end else begin
          stop_prog_nxt = stop_prog_r + 2'd1;
        end
      end else if (ch == scld_pkg::CH_LOW_S) begin
        stop_prog_nxt = 2'd1;
      end else begin
        stop_prog_nxt = 2'd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next state of the line parser.
  // --------------------------------------------------------------------------
  always_comb begin
    line_len_nxt = line_len_r;
    idle_nxt     = idle_r;
    phase_nxt    = phase_r;
    mask_nxt     = mask_r;
    num_nxt      = num_r;
    num_sat_nxt  = num_sat_r;
    do_finish    = 1'b0;

    if (in_fire) begin
      if (in_op) begin
        // Tick: count silence; a non-empty line ends at the timeout.
        idle_nxt = idle_inc;
        if (!pos_zero && idle_inc >= idle_timeout_r) begin
          do_finish = 1'b1;
        end
      end else begin
        idle_nxt = '0;
        if (is_eol) begin
          do_finish = !pos_zero;
        end else if (is_printable && line_len_r < LEN_LIMIT) begin
          line_len_nxt = line_len_r + LEN_W'(1);
          unique case (phase_r)
            scld_pkg::PH_WORD: begin
              if (pos_zero && ch == scld_pkg::CH_SPACE) begin
                phase_nxt = scld_pkg::PH_ANG_LEAD;
              end else if (pos_zero && is_digit) begin
                phase_nxt   = scld_pkg::PH_ANG_DIG;
                num_nxt     = add_val;
                num_sat_nxt = add_sat;
              end else begin
                mask_nxt = match_m;
                if (match_m == '0) begin
                  phase_nxt = scld_pkg::PH_ERROR;
                end else begin
                  // A keyword that is now complete fixes the command.
                  for (int i = 0; i < scld_pkg::NUM_WORDS; i++) begin
                    if (match_m[i] &&
                        9'(scld_pkg::word_len(3'(i))) == pos_ext + 9'd1) begin
                      mask_nxt = scld_pkg::NUM_WORDS'(1) << i;
                      if (i <= 2) begin
                        phase_nxt = scld_pkg::PH_EXACT;
                      end else if (i <= 4) begin
                        phase_nxt = scld_pkg::PH_JOG_START;
                      end else begin
                        phase_nxt = scld_pkg::PH_ANG_LEAD;
                      end
                    end
                  end
                end
              end
            end
            scld_pkg::PH_JOG_START, scld_pkg::PH_JOG_SP: begin
              if (ch == scld_pkg::CH_SPACE) begin
                phase_nxt = scld_pkg::PH_JOG_SP;
              end else if (ch == scld_pkg::CH_PLUS) begin
                phase_nxt = scld_pkg::PH_JOG_SIGN;
              end else if (is_digit) begin
                phase_nxt   = scld_pkg::PH_JOG_DIG;
                num_nxt     = add_val;
                num_sat_nxt = add_sat;
              end else begin
                phase_nxt = scld_pkg::PH_ERROR;
              end
            end
            scld_pkg::PH_JOG_SIGN, scld_pkg::PH_JOG_DIG: begin
              if (is_digit) begin
                phase_nxt   = scld_pkg::PH_JOG_DIG;
                num_nxt     = add_val;
                num_sat_nxt = add_sat;
              end else begin
                phase_nxt = scld_pkg::PH_ERROR;
              end
            end
            scld_pkg::PH_ANG_LEAD: begin
              if (is_digit) begin
                phase_nxt   = scld_pkg::PH_ANG_DIG;
                num_nxt     = add_val;
                num_sat_nxt = add_sat;
              end else if (ch != scld_pkg::CH_SPACE) begin
                phase_nxt = scld_pkg::PH_ERROR;
              end
            end
            scld_pkg::PH_ANG_DIG: begin
              if (is_digit) begin
                num_nxt     = add_val;
                num_sat_nxt = add_sat;
              end else if (ch == scld_pkg::CH_SPACE) begin
                phase_nxt = scld_pkg::PH_ANG_TRAIL;
              end else begin
                phase_nxt = scld_pkg::PH_ERROR;
              end
            end
            scld_pkg::PH_ANG_TRAIL: begin
              if (ch != scld_pkg::CH_SPACE) begin
                phase_nxt = scld_pkg::PH_ERROR;
              end
            end
            default: begin
              phase_nxt = scld_pkg::PH_ERROR;
            end
          endcase
        end
      end
    end

    // A finished line returns to the empty state.
    if (do_finish) begin
      line_len_nxt = '0;
      idle_nxt     = '0;
      phase_nxt    = scld_pkg::PH_WORD;
      mask_nxt     = scld_pkg::ALL_WORDS;
      num_nxt      = '0;
      num_sat_nxt  = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Command decode of the line as it stands.
  // --------------------------------------------------------------------------
  assign cand_kind = low_kind(mask_r);

  always_comb begin
    fin_kind  = scld_pkg::KIND_ERROR;
    fin_value = '0;
    unique case (phase_r)
      scld_pkg::PH_EXACT: begin
        fin_kind = cand_kind;
      end
      scld_pkg::PH_JOG_START: begin
        fin_kind  = cand_kind;
        fin_value = 10'd1;
      end
      scld_pkg::PH_JOG_DIG: begin
        if (!num_sat_r && num_r != '0 && num_r <= {1'b0, max_jog_r}) begin
          fin_kind  = cand_kind;
          fin_value = num_r[9:0];
        end
      end
      scld_pkg::PH_ANG_DIG, scld_pkg::PH_ANG_TRAIL: begin
        if (!num_sat_r && num_r <= scld_pkg::ANGLE_LIMIT) begin
          fin_kind  = scld_pkg::KIND_ANGLE;
          fin_value = num_r[9:0];
        end
      end
      default: begin
        fin_kind = scld_pkg::KIND_ERROR;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= scld_pkg::IDLE_TIMEOUT_RESET;
      max_jog_r      <= scld_pkg::MAX_JOG_RESET;
      line_len_r     <= '0;
      idle_r         <= '0;
      stop_prog_r    <= '0;
      phase_r        <= scld_pkg::PH_WORD;
      mask_r         <= scld_pkg::ALL_WORDS;
      num_r          <= '0;
      num_sat_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          scld_pkg::CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata[15:0];
          scld_pkg::CFG_MAX_JOG:      max_jog_r      <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      line_len_r  <= line_len_nxt;
      idle_r      <= idle_nxt;
      stop_prog_r <= stop_prog_nxt;
      phase_r     <= phase_nxt;
      mask_r      <= mask_nxt;
      num_r       <= num_nxt;
      num_sat_r   <= num_sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result payload is loaded with each accepted item and needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stop_now_r  <= stop_hit;
      cmd_ready_r <= do_finish;
      cmd_kind_r  <= do_finish ? fin_kind : scld_pkg::KIND_READ;
      cmd_value_r <= do_finish ? fin_value : 10'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `SCLD_ASSERT(a_fire_gives_result, clk, rst_n, in_fire |=> out_valid_r, "accepted item produced no result")
  `SCLD_ASSERT(a_idle_fields_zero, clk, rst_n, (out_valid_r && !cmd_ready_r) |-> (cmd_kind_r == scld_pkg::KIND_READ && cmd_value_r == 10'd0), "non-command result carries a kind or value")
  `SCLD_ASSERT(a_finish_clears_line, clk, rst_n, do_finish |=> (line_len_r == '0 && phase_r == scld_pkg::PH_WORD && idle_r == '0), "line state not cleared after a command")
  `SCLD_ASSERT(a_angle_in_range, clk, rst_n, (out_valid_r && cmd_kind_r == scld_pkg::KIND_ANGLE) |-> (cmd_value_r <= 10'd360), "angle result above limit")
  `SCLD_ASSERT_NEVER(a_line_overflow, clk, rst_n, line_len_r > LEN_LIMIT, "line length beyond its limit")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line decoder testbench
// Feeds received characters and millisecond ticks into the decoder and checks
// every result against a cycle-free model of the line parser, the stop word
// matcher and the idle timeout. Directed command lines come first, then random
// lines under four handshake idling mixes and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import scld_pkg::*;

  localparam int LINE_CAP = 40;

  // One decoded result, as the model expects it.
  typedef struct {
    logic       stop_now;
    logic       ready;
    kind_t      kind;
    logic [9:0] value;
  } decoded_t;

  logic                   clk;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic                   in_op        = 1'b0;
  logic [7:0]             in_data_byte = 8'h00;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic                   out_stop_now;
  logic                   out_command_ready;
  logic [2:0]             out_command_kind;
  logic [9:0]             out_command_value;
  logic                   cfg_wr_en    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = CFG_IDLE_TIMEOUT;
  logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;

  serial_command_line_decoder_unit #(
    .LINE_MAX(LINE_CAP)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stop_now     (out_stop_now),
    .out_command_ready(out_command_ready),
    .out_command_kind (out_command_kind),
    .out_command_value(out_command_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Keyword table, indexed by command kind for the first six kinds.
  string keywords [6] = '{"read", "stop", "help", "ccw", "cw", "angle"};

  // Model state: the register copies and the state of the line being parsed.
  logic [15:0] timeout_q;
  logic [9:0]  jog_max_q;
  logic [5:0]  line_len_q;
  logic [15:0] idle_q;
  logic [1:0]  stop_pos_q;
  phase_t      phase_q;
  logic [5:0]  cand_q;
  logic [10:0] num_q;
  logic        num_sat_q;

  // Results predicted for accepted items, oldest first.
  decoded_t pending_decodes [$];

  int gap_pct    = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random, at the rate the current phase asks for.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Model of the decoder
  // ---------------------------------------------------------------------------

  function automatic void clear_line();
    line_len_q = '0;
    idle_q     = '0;
    phase_q    = PH_WORD;
    cand_q     = ALL_WORDS;
    num_q      = '0;
    num_sat_q  = 1'b0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Decimal accumulation that sticks at the saturation value once it is hit.
  function automatic void add_digit(input logic [7:0] c);
    int unsigned v;
    v = num_q * 10 + (c - CH_ZERO);
    if (num_sat_q || v > NUM_SAT) begin
      v         = NUM_SAT;
      num_sat_q = 1'b1;
    end
    num_q = v[10:0];
  endfunction

  // Ends the current line: classifies what was parsed, then starts a new line.
  function automatic decoded_t close_line();
    decoded_t    r;
    int unsigned word;
    word = 0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (cand_q[i]) word = i;
    end
    r.stop_now = 1'b0;
    r.ready    = 1'b1;
    r.kind     = KIND_ERROR;
    r.value    = '0;
    case (phase_q)
      PH_EXACT: r.kind = kind_t'(word);
      PH_JOG_START: begin
        // A jog word with no count means a count of one.
        r.kind  = kind_t'(word);
        r.value = 10'd1;
      end
      PH_JOG_DIG: begin
        if (!num_sat_q && num_q != 0 && num_q <= jog_max_q) begin
          r.kind  = kind_t'(word);
          r.value = num_q[9:0];
        end
      end
      PH_ANG_DIG, PH_ANG_TRAIL: begin
        if (!num_sat_q && num_q <= ANGLE_LIMIT) begin
          r.kind  = KIND_ANGLE;
          r.value = num_q[9:0];
        end
      end
      default: ;
    endcase
    clear_line();
    return r;
  endfunction

  // Works out the result of one accepted item and advances the model state.
  function automatic decoded_t decode_item(input logic op, input logic [7:0] b);
    decoded_t    r;
    logic [7:0]  c;
    logic        stop_hit;
    logic [5:0]  m;
    int unsigned pos;
    r.stop_now = 1'b0;
    r.ready    = 1'b0;
    r.kind     = KIND_READ;
    r.value    = '0;
    if (op) begin
      // A tick: count silence and end a non-empty line once it is long enough.
      if (idle_q != 16'hFFFF) idle_q++;
      if (line_len_q != 0 && idle_q >= timeout_q) r = close_line();
      return r;
    end
    c = (b >= CH_UA && b <= CH_UZ) ? b + 8'd32 : b;
    // The stop word matcher sees every byte, kept or dropped.
    stop_hit = 1'b0;
    if (c == keywords[KIND_STOP][stop_pos_q]) begin
      if (stop_pos_q == 2'd3) begin
        stop_hit   = 1'b1;
        stop_pos_q = 2'd0;
      end else begin
        stop_pos_q++;
      end
    end else begin
      stop_pos_q = (c == CH_LOW_S) ? 2'd1 : 2'd0;
    end
    idle_q = '0;
    if (b == CH_CR || b == CH_LF) begin
      if (line_len_q != 0) r = close_line();
    end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI && line_len_q < LINE_CAP - 1) begin
      pos = line_len_q;
      case (phase_q)
        PH_WORD: begin
          if (pos == 0 && c == CH_SPACE) begin
            phase_q = PH_ANG_LEAD;
          end else if (pos == 0 && is_digit(c)) begin
            phase_q = PH_ANG_DIG;
            add_digit(c);
          end else begin
            // Narrow down the keywords that still agree with the line so far.
            m = '0;
            for (int i = 0; i < NUM_WORDS; i++) begin
              if (cand_q[i] && pos < keywords[i].len() && keywords[i][pos] == c) m[i] = 1'b1;
            end
            cand_q = m;
            if (m == 0) begin
              phase_q = PH_ERROR;
            end else begin
              for (int i = 0; i < NUM_WORDS; i++) begin
                if (m[i] && keywords[i].len() == pos + 1) begin
                  cand_q = 6'b1 << i;
                  if (i <= KIND_HELP) begin
                    phase_q = PH_EXACT;
                  end else if (i <= KIND_CW) begin
                    phase_q = PH_JOG_START;
                  end else begin
                    phase_q = PH_ANG_LEAD;
                  end
                end
              end
            end
          end
        end
        PH_JOG_START, PH_JOG_SP: begin
          if (c == CH_SPACE) begin
            phase_q = PH_JOG_SP;
          end else if (c == CH_PLUS) begin
            phase_q = PH_JOG_SIGN;
          end else if (is_digit(c)) begin
            phase_q = PH_JOG_DIG;
            add_digit(c);
          end else begin
            phase_q = PH_ERROR;
          end
        end
        PH_JOG_SIGN, PH_JOG_DIG: begin
          if (is_digit(c)) begin
            phase_q = PH_JOG_DIG;
            add_digit(c);
          end else begin
            phase_q = PH_ERROR;
          end
        end
        PH_ANG_LEAD: begin
          if (is_digit(c)) begin
            phase_q = PH_ANG_DIG;
            add_digit(c);
          end else if (c != CH_SPACE) begin
            phase_q = PH_ERROR;
          end
        end
        PH_ANG_DIG: begin
          if (is_digit(c)) begin
            add_digit(c);
          end else if (c == CH_SPACE) begin
            phase_q = PH_ANG_TRAIL;
          end else begin
            phase_q = PH_ERROR;
          end
        end
        PH_ANG_TRAIL: begin
          if (c != CH_SPACE) phase_q = PH_ERROR;
        end
        default: phase_q = PH_ERROR;
      endcase
      line_len_q++;
    end
    r.stop_now = stop_hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking. Both sides are sampled at the rising edge in one process: the
  // result leaving at this edge belongs to an item accepted at an earlier edge,
  // so it is compared before the item accepted now is predicted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    decoded_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no item waiting: stop=%0b ready=%0b kind=%0d value=%0d",
                     $realtime, out_stop_now, out_command_ready, out_command_kind,
                     out_command_value);
          end
        end else begin
          want = pending_decodes.pop_front();
          if (out_stop_now !== want.stop_now || out_command_ready !== want.ready ||
              out_command_kind !== want.kind || out_command_value !== want.value) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected stop=%0b ready=%0b kind=%0d value=%0d", $realtime,
                       want.stop_now, want.ready, want.kind, want.value);
              $display("%0t:   actual stop=%0b ready=%0b kind=%0d value=%0d", $realtime,
                       out_stop_now, out_command_ready, out_command_kind, out_command_value);
            end
          end
        end
      end
      if (in_valid && !in_stall) pending_decodes.push_back(decode_item(in_op, in_data_byte));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until the decoder takes it. Valid stays high
  // afterwards so that back-to-back items need no bubble; drain lowers it.
  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_op        = op;
    in_data_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Tick items carry random bytes, which the decoder must ignore.
  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_item(1'b0, s[k]);
  endtask

  task automatic send_line(input string body, input logic [7:0] term);
    send_text(body);
    send_item(1'b0, term);
  endtask

  // Waits until every predicted result has come out and the decoder is quiet.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Registers change only while no item is in flight.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    if (idx == CFG_IDLE_TIMEOUT) begin
      timeout_q = value;
    end else begin
      jog_max_q = value[9:0];
    end
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Read, stop, help and ccw in mixed case, plus a cut-short and an overlong keyword.
  task automatic test_keywords();
    send_line("read", CH_CR);
    send_line("STOP", CH_LF);
    send_line("Help", CH_CR);
    send_line("ccw", CH_CR);
    send_line("rea", CH_CR);
    send_line("reads", CH_LF);
  endtask

  // Jog counts: the limit and one past it, a plus sign, zero, a minus sign,
  // junk after the digits, a bare sign and trailing spaces.
  task automatic test_jog_counts();
    send_line("cw 20", CH_CR);
    send_line("cw21", CH_CR);
    send_line("CCW  +5", CH_LF);
    send_line("cw0", CH_CR);
    send_line("cw -3", CH_CR);
    send_line("ccw 7x", CH_CR);
    send_line("cw+", CH_CR);
    send_line("cw  ", CH_CR);
  endtask

  // Angles with and without the keyword, the range edge, saturation, a bare
  // keyword and junk after the trailing spaces.
  task automatic test_angles();
    send_line("angle 360 ", CH_CR);
    send_line("angle361", CH_CR);
    send_line(" 0", CH_LF);
    send_line("360", CH_CR);
    send_line("99999", CH_CR);
    send_line("angle", CH_CR);
    send_line("angle 12 x", CH_CR);
  endtask

  // Non-printable bytes vanish from the line; an empty line yields nothing.
  task automatic test_dropped_bytes();
    send_item(1'b0, "r");
    send_item(1'b0, 8'h00);
    send_item(1'b0, "e");
    send_item(1'b0, 8'h7F);
    send_item(1'b0, "a");
    send_item(1'b0, 8'hFF);
    send_item(1'b0, "d");
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h1F);
    send_item(1'b0, CH_CR);
    send_item(1'b0, CH_CR);
    send_item(1'b0, CH_LF);
  endtask

  // A full line drops further characters, yet the stop matcher still fires on
  // them. A doubled s restarts the matcher one character in.
  task automatic test_full_line();
    string s;
    s = "angle 5";
    while (s.len() < LINE_CAP - 1) s = {s, " "};
    send_line({s, "xySTOP"}, CH_CR);
    send_line("xsstop", CH_CR);
  endtask

  // The default timeout ends a line; a dropped byte restarts the silence count.
  task automatic test_idle_timeout();
    send_text("help");
    send_ticks(49);
    send_item(1'b0, 8'h01);
    send_ticks(51);
  endtask

  // Register extremes: a zero timeout and a zero jog limit, then the widest
  // jog limit, then the longest timeout, which a short silence does not reach.
  task automatic test_register_extremes();
    write_register(CFG_IDLE_TIMEOUT, 16'd0);
    write_register(CFG_MAX_JOG, 16'd0);
    send_ticks(2);
    send_text("cw");
    send_ticks(1);
    send_line("cw1", CH_CR);
    send_text("READ");
    send_ticks(1);
    write_register(CFG_IDLE_TIMEOUT, 16'd1);
    write_register(CFG_MAX_JOG, 16'hFFFF);
    send_line("ccw1023", CH_LF);
    send_line("ccw 1024", CH_CR);
    send_text("cw+0009");
    send_ticks(1);
    write_register(CFG_IDLE_TIMEOUT, 16'hFFFF);
    send_text("read");
    send_ticks(20);
    send_item(1'b0, CH_CR);
  endtask

  // ---------------------------------------------------------------------------
  // Random lines
  // ---------------------------------------------------------------------------

  // Mostly well-formed commands with random numbers and spacing, some with one
  // character spoiled, and some printable noise. Letters get random case.
  function automatic string random_body();
    string s;
    int    sel;
    int    pick;
    sel = $urandom_range(99);
    if (sel < 15) begin
      s = keywords[$urandom_range(KIND_HELP)];
    end else if (sel < 45) begin
      if ($urandom_range(1)) s = "cw";
      else s = "ccw";
      repeat ($urandom_range(2)) s = {s, " "};
      pick = $urandom_range(9);
      if (pick == 0) s = {s, "+"};
      if (pick == 1) s = {s, "-"};
      pick = $urandom_range(9);
      if (pick == 1) s = {s, "0"};
      else if (pick <= 6) s = $sformatf("%s%0d", s, $urandom_range(1, jog_max_q));
      else if (pick == 7) s = $sformatf("%s%0d", s, jog_max_q + 1);
      else if (pick == 8) s = $sformatf("%s%0d", s, $urandom_range(99999));
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) s = {s, "x"};
        else s = {s, " "};
      end
    end else if (sel < 75) begin
      if ($urandom_range(1)) s = "angle";
      else s = "";
      repeat ($urandom_range(2)) s = {s, " "};
      pick = $urandom_range(9);
      if (pick <= 6) s = $sformatf("%s%0d", s, $urandom_range(ANGLE_LIMIT));
      else if (pick <= 8) s = $sformatf("%s%0d", s, $urandom_range(361, 400));
      else s = $sformatf("%s%0d", s, $urandom_range(2000, 99999));
      repeat ($urandom_range(3)) s = {s, " "};
      if ($urandom_range(19) == 0) begin
        repeat (40) s = {s, " "};
      end
    end else if (sel < 85) begin
      s = $sformatf("%s %0d", keywords[$urandom_range(NUM_WORDS - 1)], $urandom_range(30));
      s[$urandom_range(s.len() - 1)] = 8'($urandom_range(32, 126));
    end else begin
      s = "";
      repeat ($urandom_range(45)) s = $sformatf("%s%c", s, $urandom_range(32, 126));
    end
    for (int k = 0; k < s.len(); k++) begin
      if (s[k] >= "a" && s[k] <= "z" && $urandom_range(1)) s[k] = s[k] - 8'd32;
    end
    return s;
  endfunction

  // Sends one random line. Stray bytes and short tick bursts are sprinkled in,
  // and the line ends at CR, LF, CR LF or by timeout.
  task automatic send_random_line();
    string s;
    int    pick;
    s = random_body();
    if ($urandom_range(19) == 0) begin
      // Raw noise over the whole byte range, line ends included.
      repeat ($urandom_range(1, 10)) send_item(1'b0, 8'($urandom_range(255)));
    end
    for (int k = 0; k < s.len(); k++) begin
      if ($urandom_range(19) == 0) begin
        send_item(1'b0, $urandom_range(1) ? 8'($urandom_range(128, 255))
                                          : 8'($urandom_range(0, 8)));
      end
      if (timeout_q > 1 && $urandom_range(19) == 0) begin
        send_ticks($urandom_range(1, (timeout_q > 4) ? 3 : timeout_q - 1));
      end
      send_item(1'b0, s[k]);
    end
    pick = $urandom_range(9);
    if (pick <= 3) begin
      send_item(1'b0, CH_CR);
    end else if (pick <= 6) begin
      send_item(1'b0, CH_LF);
    end else if (pick == 7) begin
      send_item(1'b0, CH_CR);
      send_item(1'b0, CH_LF);
    end else begin
      send_ticks(timeout_q + $urandom_range(2));
    end
  endtask

  // One phase of random traffic under one idling mix and one register setting.
  task automatic test_random_traffic(input int gap, input int stall,
                                     input logic [15:0] timeout, input logic [15:0] jog_max,
                                     input int count);
    int start;
    write_register(CFG_IDLE_TIMEOUT, timeout);
    write_register(CFG_MAX_JOG, jog_max);
    gap_pct   = gap;
    stall_pct = stall;
    start     = items_sent;
    while (items_sent - start < count) send_random_line();
    drain();
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    timeout_q  = IDLE_TIMEOUT_RESET;
    jog_max_q  = MAX_JOG_RESET;
    stop_pos_q = '0;
    clear_line();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_keywords();
    test_jog_counts();
    test_angles();
    test_dropped_bytes();
    test_full_line();
    test_idle_timeout();
    test_register_extremes();

    test_random_traffic(0, 0, 16'd4, 16'd20, 125);
    test_random_traffic(64, 0, 16'd2, 16'd1023, 125);
    test_random_traffic(0, 64, 16'd9, 16'd1, 125);
    test_random_traffic(35, 35, 16'd1, 16'd300, 125);

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
